[design/dse_pkg.sv]
// Shared types, constants and Q8.24 helpers for the SDE element update block.
// No dependencies; every other design file except dse_ram imports this package.
`default_nettype none

package dse_pkg;

	localparam int IDX_W = 14;
	localparam int Q_W = 32;
	localparam int PROD_W = 64;
	localparam int RND_W = 40;
	localparam int WIDE_W = 42;
	localparam int CFG_IDX_W = 3;
	localparam int QUEUE_DEPTH = 4;
	localparam longint IDX_MAX = (64'd1 << IDX_W) - 64'd1;

	// 0.5 LSB of a Q8.24 product before the shift
	localparam logic signed [PROD_W-1:0] HALF_LSB = 64'sd8388608;
	localparam logic signed [Q_W-1:0] ONE_Q = 32'sd16777216;
	localparam logic signed [WIDE_W-1:0] W_MAX = 42'sd2147483647;
	localparam logic signed [WIDE_W-1:0] W_MIN = -42'sd2147483648;

	localparam logic [CFG_IDX_W-1:0] REG_COEF_SAMPLE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_CLEAN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_NOISE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SIGMA_SOURCE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INV_ALPHA_SOURCE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_INV_RATIO = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SECOND_ORDER = 3'd6;

	typedef struct packed {
		logic signed [Q_W-1:0] coef_sample;
		logic signed [Q_W-1:0] coef_clean;
		logic signed [Q_W-1:0] coef_noise;
		logic signed [Q_W-1:0] sigma_source;
		logic signed [Q_W-1:0] inv_alpha_source;
		logic signed [Q_W-1:0] half_inv_ratio;
		logic second_order;
	} cfg_t;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic signed [Q_W-1:0] sample;
		logic signed [Q_W-1:0] eps;
		logic signed [Q_W-1:0] noise;
	} item_t;

	function automatic logic signed [RND_W-1:0] q_round(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] t;
		t = p + HALF_LSB;
		return t[PROD_W-1:24];
	endfunction

	function automatic logic signed [Q_W-1:0] q_clip(input logic signed [WIDE_W-1:0] v);
		logic signed [Q_W-1:0] r;
		if (v > W_MAX) begin
			r = W_MAX[Q_W-1:0];
		end else if (v < W_MIN) begin
			r = W_MIN[Q_W-1:0];
		end else begin
			r = v[Q_W-1:0];
		end
		return r;
	endfunction

	function automatic logic q_over(input logic signed [WIDE_W-1:0] v);
		return (v > W_MAX) || (v < W_MIN);
	endfunction

endpackage

`default_nettype wire

[design/dse_ifs.sv]
// Stream interfaces for the element item and the result item.
// Depends on dse_pkg for field widths.
`default_nettype none

interface dse_in_if import dse_pkg::*; ();
	logic valid;
	logic ready;
	logic [IDX_W-1:0] elem_index;
	logic signed [Q_W-1:0] sample_value;
	logic signed [Q_W-1:0] eps_value;
	logic signed [Q_W-1:0] noise_value;

	modport source(output valid, output elem_index, output sample_value,
		output eps_value, output noise_value, input ready);
	modport sink(input valid, input elem_index, input sample_value,
		input eps_value, input noise_value, output ready);
endinterface

interface dse_out_if import dse_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [Q_W-1:0] new_sample;
	logic saturated;

	modport source(output valid, output new_sample, output saturated, input ready);
	modport sink(input valid, input new_sample, input saturated, output ready);
endinterface

`default_nettype wire

[design/dse_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module dse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16384
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic                                  re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[design/dse_front.sv]
// Front end: accepts element items, folds the index into the store range.
// Depends on dse_pkg and dse_in_if.
`default_nettype none

module dse_front import dse_pkg::*; #(
	parameter int ELEMENTS = 16384
) (
	input  wire logic clk,
	input  wire logic arst_n,
	dse_in_if.sink    items,
	input  wire logic q_full,
	output logic      push_valid,
	output item_t     push_item
);

	localparam int SPLIT = IDX_W / 2;

	// conditional subtract of ELEMENTS << k for k = hi downto lo
	function automatic logic [IDX_W-1:0] idx_reduce(input logic [IDX_W-1:0] v,
		input int hi, input int lo);
		logic [IDX_W-1:0] t;
		t = v;
		for (int k = hi; k >= lo; k--) begin
			if ((longint'(ELEMENTS) << k) <= IDX_MAX) begin
				if (longint'(t) >= (longint'(ELEMENTS) << k)) begin
					t = t - IDX_W'(longint'(ELEMENTS) << k);
				end
			end
		end
		return t;
	endfunction

	logic  v_f1;
	item_t item_f1;
	logic  hold;

	assign hold = v_f1 && q_full;
	assign items.ready = !hold;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_f1 <= 1'b0;
		end else if (!hold) begin
			v_f1 <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!hold && items.valid) begin
			item_f1.idx <= idx_reduce(items.elem_index, IDX_W - 1, SPLIT);
			item_f1.sample <= items.sample_value;
			item_f1.eps <= items.eps_value;
			item_f1.noise <= items.noise_value;
		end
	end

	always_comb begin
		push_item = item_f1;
		push_item.idx = idx_reduce(item_f1.idx, SPLIT - 1, 0);
	end

	assign push_valid = v_f1 && !q_full;

endmodule

`default_nettype wire

[design/dse_queue.sv]
// Short item queue between the front end and the update pipeline.
// Depends on dse_pkg.
`default_nettype none

module dse_queue import dse_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push_valid,
	input  wire item_t push_item,
	output logic       full,
	input  wire logic  pop,
	output logic       pop_valid,
	output item_t      pop_item
);

	localparam int PW = $clog2(QUEUE_DEPTH);

	item_t         mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;

	assign full = count_q == (PW + 1)'(QUEUE_DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push_valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push_valid && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push_valid) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_valid) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid |-> !full)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> pop_valid)
		else $error("pop from empty queue");

endmodule

`default_nettype wire

[design/dse_back.sv]
// Update pipeline: clean estimate, midpoint correction, weighted sum, output register.
// Depends on dse_pkg, dse_out_if and dse_ram (previous clean estimates).
`default_nettype none

module dse_back import dse_pkg::*; #(
	parameter int ELEMENTS = 16384
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cfg_t  cfg,
	input  wire logic  q_valid,
	input  wire item_t q_item,
	output logic       q_pop,
	dse_out_if.source  results
);

	localparam int AW = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;

	logic adv;
	logic so;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic out_valid_q;
	logic fwd_s3;

	logic [IDX_W-1:0] idx_s1, idx_s2, idx_s3, idx_s4;
	logic signed [Q_W-1:0] s_s1;
	logic signed [PROD_W-1:0] pse_s1, psm_s1, pno_s1;

	logic signed [Q_W-1:0] d_s2;
	logic signed [RND_W-1:0] rs_s2, rn_s2, rs_s3, rn_s3, rs_s4, rn_s4;
	logic signed [RND_W-1:0] rs_s5, rn_s5, rs_s6, rn_s6, rs_s7, rn_s7;
	logic flag_s2, flag_s3, flag_s4, flag_s5, flag_s6, flag_s7;

	logic signed [PROD_W-1:0] px_s3, pc_s5, pm_s7;
	logic signed [Q_W-1:0] x0_s4, diff_s4, x0_s5, m_s6;
	logic signed [Q_W-1:0] out_sample_q;
	logic out_flag_q;

	logic signed [RND_W-1:0] se_r, x_r, c_r;
	logic signed [Q_W-1:0] se, d, x0, prev, diff, corr, m_c, m;
	logic signed [WIDE_W-1:0] d_w, diff_w, m_w, sum_w;
	logic f_se, f_d, f_x, f_df, f_c, f_m;
	logic [Q_W-1:0] ram_rdata;

	assign so = cfg.second_order;
	assign adv = !out_valid_q || results.ready;
	assign q_pop = adv && q_valid;

	always_comb begin
		se_r = q_round(pse_s1);
		se = q_clip(WIDE_W'(se_r));
		f_se = q_over(WIDE_W'(se_r));
		d_w = WIDE_W'(s_s1) - WIDE_W'(se);
		d = q_clip(d_w);
		f_d = q_over(d_w);

		x_r = q_round(px_s3);
		x0 = q_clip(WIDE_W'(x_r));
		f_x = q_over(WIDE_W'(x_r));
		prev = fwd_s3 ? x0_s4 : $signed(ram_rdata);
		diff_w = WIDE_W'(x0) - WIDE_W'(prev);
		diff = q_clip(diff_w);
		f_df = q_over(diff_w);

		c_r = q_round(pc_s5);
		corr = q_clip(WIDE_W'(c_r));
		f_c = q_over(WIDE_W'(c_r));
		m_w = WIDE_W'(x0_s5) + WIDE_W'(corr);
		m_c = q_clip(m_w);
		f_m = q_over(m_w);
		m = so ? m_c : x0_s5;

		sum_w = WIDE_W'(rs_s7) + WIDE_W'(rn_s7) + WIDE_W'(q_round(pm_s7));
	end

	dse_ram #(
		.WIDTH(Q_W),
		.DEPTH(ELEMENTS)
	) u_prev_ram (
		.clk  (clk),
		.we   (adv && v_s3),
		.waddr(AW'(idx_s3)),
		.wdata(x0),
		.re   (adv),
		.raddr(AW'(idx_s2)),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			out_valid_q <= 1'b0;
			fwd_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= q_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			out_valid_q <= v_s7;
			// read and write of the same entry on this edge
			fwd_s3 <= v_s2 && v_s3 && (idx_s2 == idx_s3);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s1 <= q_item.idx;
			s_s1 <= q_item.sample;
			pse_s1 <= cfg.sigma_source * q_item.eps;
			psm_s1 <= cfg.coef_sample * q_item.sample;
			pno_s1 <= cfg.coef_noise * q_item.noise;

			idx_s2 <= idx_s1;
			d_s2 <= d;
			flag_s2 <= f_se | f_d;
			rs_s2 <= q_round(psm_s1);
			rn_s2 <= q_round(pno_s1);

			idx_s3 <= idx_s2;
			px_s3 <= d_s2 * cfg.inv_alpha_source;
			flag_s3 <= flag_s2;
			rs_s3 <= rs_s2;
			rn_s3 <= rn_s2;

			idx_s4 <= idx_s3;
			x0_s4 <= x0;
			diff_s4 <= diff;
			flag_s4 <= flag_s3 | f_x | (so & f_df);
			rs_s4 <= rs_s3;
			rn_s4 <= rn_s3;

			pc_s5 <= cfg.half_inv_ratio * diff_s4;
			x0_s5 <= x0_s4;
			flag_s5 <= flag_s4;
			rs_s5 <= rs_s4;
			rn_s5 <= rn_s4;

			m_s6 <= m;
			flag_s6 <= flag_s5 | (so & (f_c | f_m));
			rs_s6 <= rs_s5;
			rn_s6 <= rn_s5;

			pm_s7 <= cfg.coef_clean * m_s6;
			flag_s7 <= flag_s6;
			rs_s7 <= rs_s6;
			rn_s7 <= rn_s6;

			out_sample_q <= q_clip(sum_w);
			out_flag_q <= flag_s7 | q_over(sum_w);
		end
	end

	assign results.valid = out_valid_q;
	assign results.new_sample = out_sample_q;
	assign results.saturated = out_flag_q;

	a_fwd_source: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_s3 |-> (v_s3 && v_s4 && idx_s3 == idx_s4))
		else $error("forwarded clean estimate does not match store index");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && v_s7) |=> out_valid_q)
		else $error("result lost at output register");

endmodule

`default_nettype wire

[design/dpm_solver_sde_element_update.sv]
// Top level of the SDE element update: config registers, front end, queue, update pipeline.
// Depends on dse_pkg, dse_ifs, dse_front, dse_queue, dse_back, dse_ram.
//
//  port      dir    handshake      payload
//  items     sink   valid/ready    elem_index, sample_value, eps_value, noise_value
//  results   source valid/ready    new_sample, saturated
//  cfg       sink   cfg_wr_en      cfg_index, cfg_data
//
// One item per cycle unless results stall; an item passes front, queue, s1-s7, output reg.
// The eight-stage update pipeline advances only while its output register can drain.
// A four-entry queue lets the front end keep taking items while results are stalled.
// Reset clears control and loads config defaults; the clean-estimate store is undefined until written.
`default_nettype none

module dpm_solver_sde_element_update import dse_pkg::*; #(
	parameter int ELEMENTS = 16384
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	dse_in_if.sink                    items,
	dse_out_if.source                 results,
	input  wire logic                 cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [Q_W-1:0]       cfg_data
);

	cfg_t  cfg_q;
	logic  push_valid;
	item_t push_item;
	logic  q_full;
	logic  q_pop;
	logic  q_valid;
	item_t q_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.coef_sample <= ONE_Q;
			cfg_q.coef_clean <= '0;
			cfg_q.coef_noise <= '0;
			cfg_q.sigma_source <= '0;
			cfg_q.inv_alpha_source <= ONE_Q;
			cfg_q.half_inv_ratio <= '0;
			cfg_q.second_order <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_COEF_SAMPLE: cfg_q.coef_sample <= $signed(cfg_data);
				REG_COEF_CLEAN: cfg_q.coef_clean <= $signed(cfg_data);
				REG_COEF_NOISE: cfg_q.coef_noise <= $signed(cfg_data);
				REG_SIGMA_SOURCE: cfg_q.sigma_source <= $signed(cfg_data);
				REG_INV_ALPHA_SOURCE: cfg_q.inv_alpha_source <= $signed(cfg_data);
				REG_HALF_INV_RATIO: cfg_q.half_inv_ratio <= $signed(cfg_data);
				REG_SECOND_ORDER: cfg_q.second_order <= cfg_data[0];
				default: ;
			endcase
		end
	end

	dse_front #(
		.ELEMENTS(ELEMENTS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (items),
		.q_full    (q_full),
		.push_valid(push_valid),
		.push_item (push_item)
	);

	dse_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.pop_valid (q_valid),
		.pop_item  (q_item)
	);

	dse_back #(
		.ELEMENTS(ELEMENTS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.q_valid(q_valid),
		.q_item (q_item),
		.q_pop  (q_pop),
		.results(results)
	);

endmodule

`default_nettype wire

[bench/dpm_solver_sde_element_update_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for dpm_solver_sde_element_update: directed table, then random phases.
// Needs dse_pkg, dse_ifs and the block; the Q8.24 predictor and clean-estimate store live here.

module dpm_solver_sde_element_update_test;
	import dse_pkg::*;

	localparam logic [Q_W-1:0] Q_MAX_V = 32'h7FFF_FFFF;
	localparam logic [Q_W-1:0] Q_MIN_V = 32'h8000_0000;
	localparam logic [Q_W-1:0] Q_ONE = 32'h0100_0000;
	localparam logic [Q_W-1:0] Q_HALF = 32'h0080_0000;
	localparam logic [Q_W-1:0] Q_NEG1 = 32'hFFFF_FFFF;
	localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
	localparam int unsigned VALUE_SPAN = 32'h0800_0000;
	localparam int unsigned COEF_SPAN = 32'h0200_0000;
	localparam int DEPTH = 16384;
	localparam int PHASE_ITEMS = 250;
	localparam int RANDOM_PHASES = 8;
	localparam int HOLD_CYCLES = 200;
	localparam int CYCLE_LIMIT = 200000;
	localparam int MAX_REPORTS = 100;
	localparam int DIRECTED_ROWS = 23;

	typedef struct packed {
		logic signed [Q_W-1:0] new_sample;
		logic saturated;
	} result_t;

	typedef struct packed {
		logic [2:0] phase;
		logic [IDX_W-1:0] idx;
		logic [Q_W-1:0] sample;
		logic [Q_W-1:0] eps;
		logic [Q_W-1:0] noise;
		logic typed;
		logic [Q_W-1:0] want_sample;
		logic want_sat;
	} directed_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [Q_W-1:0] cfg_data;

	dse_in_if items_if();
	dse_out_if results_if();

	dpm_solver_sde_element_update #(.ELEMENTS(DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.items(items_if),
		.results(results_if),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	cfg_t shadow;
	int clean_store [0:DEPTH-1];
	bit clean_written [0:DEPTH-1];
	logic [IDX_W-1:0] written_idx [$];
	result_t pending_results [$];
	int idle_pct = 0;
	int stall_pct = 0;
	int hold_requests = 0;
	int error_count = 0;
	int cycle_count = 0;

	// rows grouped by phase; phase 0 runs on reset settings
	directed_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
		'{3'd0, 14'd0, 32'h0, Q_MAX_V, Q_MIN_V, 1'b1, 32'h0, 1'b0},
		'{3'd0, 14'd16383, Q_MAX_V, Q_MIN_V, Q_MAX_V, 1'b1, Q_MAX_V, 1'b0},
		'{3'd0, 14'd1, Q_MIN_V, 32'h0, 32'h0, 1'b1, Q_MIN_V, 1'b0},
		'{3'd0, 14'd2, 32'h1, Q_NEG1, 32'h1, 1'b1, 32'h1, 1'b0},
		'{3'd0, 14'd3, Q_NEG1, 32'h1, Q_NEG1, 1'b1, Q_NEG1, 1'b0},
		'{3'd0, 14'd8191, 32'h1234_5678, 32'hA5A5_5A5A, 32'h0F0F_F0F0, 1'b1, 32'h1234_5678, 1'b0},
		'{3'd1, 14'd4, Q_MAX_V, 32'h0, 32'h0, 1'b1, Q_MAX_V, 1'b1},
		'{3'd1, 14'd5, Q_MIN_V, 32'h0, 32'h0, 1'b1, Q_MIN_V, 1'b1},
		'{3'd1, 14'd6, 32'h0, Q_MAX_V, 32'h0, 1'b1, 32'h0, 1'b1},
		'{3'd1, 14'd7, 32'h0, 32'h0, 32'h0, 1'b1, 32'h0, 1'b0},
		'{3'd1, 14'd8, Q_ONE, 32'h0, 32'h0, 1'b1, Q_MAX_V, 1'b0},
		'{3'd2, 14'd16383, Q_MIN_V, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
		'{3'd2, 14'd1, Q_MAX_V, Q_MIN_V, 32'h0, 1'b0, 32'h0, 1'b0},
		'{3'd2, 14'd0, 32'h0200_0000, Q_ONE, Q_MAX_V, 1'b0, 32'h0, 1'b0},
		'{3'd2, 14'd0, 32'hFD00_0000, Q_HALF, Q_MIN_V, 1'b0, 32'h0, 1'b0},
		'{3'd2, 14'd0, 32'h0000_0001, Q_NEG1, Q_HALF, 1'b0, 32'h0, 1'b0},
		'{3'd2, 14'd2, 32'h7654_3210, 32'h89AB_CDEF, 32'h0, 1'b0, 32'h0, 1'b0},
		'{3'd3, 14'd3, Q_ONE, Q_ONE, Q_ONE, 1'b0, 32'h0, 1'b0},
		'{3'd3, 14'd4, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
		'{3'd3, 14'd5, 32'hFFF0_0000, 32'h0010_0000, Q_MAX_V, 1'b0, 32'h0, 1'b0},
		'{3'd4, 14'd9, Q_MAX_V, Q_MAX_V, Q_MAX_V, 1'b0, 32'h0, 1'b0},
		'{3'd4, 14'd10, Q_MIN_V, Q_MIN_V, Q_MIN_V, 1'b0, 32'h0, 1'b0},
		'{3'd4, 14'd11, 32'h0000_8000, 32'h0100_0001, 32'hFFFF_8000, 1'b0, 32'h0, 1'b0}
	};

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("dpm_solver_sde_element_update_test failed");
			$finish;
		end
	end

	function automatic longint q_product(longint a, longint b);
		return (a * b + 64'sd8388608) >>> 24;
	endfunction

	function automatic longint q_limit(longint v, inout bit clipped);
		if (v > 64'sd2147483647) begin
			clipped = 1'b1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			clipped = 1'b1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	// expected update for one element; also records the new clean estimate
	function automatic result_t predict_update(item_t it);
		bit clipped;
		longint s, e, n, x0, mid, diff, corr, acc;
		result_t r;
		clipped = 1'b0;
		s = longint'(it.sample);
		e = longint'(it.eps);
		n = longint'(it.noise);
		x0 = q_limit(q_product(shadow.sigma_source, e), clipped);
		x0 = q_limit(s - x0, clipped);
		x0 = q_limit(q_product(x0, shadow.inv_alpha_source), clipped);
		mid = x0;
		if (shadow.second_order) begin
			diff = q_limit(x0 - longint'(clean_store[it.idx]), clipped);
			corr = q_limit(q_product(shadow.half_inv_ratio, diff), clipped);
			mid = q_limit(x0 + corr, clipped);
		end
		acc = q_product(shadow.coef_sample, s) + q_product(shadow.coef_clean, mid)
			+ q_product(shadow.coef_noise, n);
		acc = q_limit(acc, clipped);
		clean_store[it.idx] = int'(x0);
		if (!clean_written[it.idx]) begin
			clean_written[it.idx] = 1'b1;
			written_idx.push_back(it.idx);
		end
		r.new_sample = acc[Q_W-1:0];
		r.saturated = clipped;
		return r;
	endfunction

	function automatic logic [Q_W-1:0] rand_q(int unsigned span);
		int unsigned pick;
		pick = $urandom_range(0, 15);
		case (pick)
			0: return Q_MAX_V;
			1: return Q_MIN_V;
			2: return '0;
			3, 4: return $urandom;
			default: return $urandom_range(0, 2 * span) - span;
		endcase
	endfunction

	// second-order reads must hit entries already written
	function automatic logic [IDX_W-1:0] rand_index();
		int unsigned pick;
		if (shadow.second_order) begin
			return written_idx[$urandom_range(0, written_idx.size() - 1)];
		end
		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			return IDX_W'($urandom_range(0, 63));
		end
		if (pick < 70) begin
			return pick[0] ? '1 : '0;
		end
		return IDX_W'($urandom);
	endfunction

	task automatic program_reg(input logic [CFG_IDX_W-1:0] idx, input logic [Q_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		case (idx)
			REG_COEF_SAMPLE: shadow.coef_sample = value;
			REG_COEF_CLEAN: shadow.coef_clean = value;
			REG_COEF_NOISE: shadow.coef_noise = value;
			REG_SIGMA_SOURCE: shadow.sigma_source = value;
			REG_INV_ALPHA_SOURCE: shadow.inv_alpha_source = value;
			REG_HALF_INV_RATIO: shadow.half_inv_ratio = value;
			REG_SECOND_ORDER: shadow.second_order = value[0];
			default: ;
		endcase
	endtask

	task automatic load_directed_settings(input int phase);
		case (phase)
			1: begin
				program_reg(REG_COEF_SAMPLE, Q_MAX_V);
				program_reg(REG_SIGMA_SOURCE, Q_MAX_V);
			end
			2: begin
				program_reg(REG_COEF_SAMPLE, '0);
				program_reg(REG_COEF_CLEAN, Q_ONE);
				program_reg(REG_COEF_NOISE, Q_ONE);
				program_reg(REG_SIGMA_SOURCE, Q_ONE);
				program_reg(REG_INV_ALPHA_SOURCE, Q_ONE);
				program_reg(REG_HALF_INV_RATIO, Q_HALF);
				program_reg(REG_SECOND_ORDER, 32'h1);
			end
			3: begin
				program_reg(REG_COEF_SAMPLE, Q_MIN_V);
				program_reg(REG_COEF_CLEAN, Q_MIN_V);
				program_reg(REG_COEF_NOISE, Q_MIN_V);
				program_reg(REG_SIGMA_SOURCE, Q_MIN_V);
				program_reg(REG_INV_ALPHA_SOURCE, Q_MIN_V);
				program_reg(REG_HALF_INV_RATIO, Q_MIN_V);
			end
			default: begin
				program_reg(REG_COEF_CLEAN, Q_MAX_V);
				program_reg(REG_COEF_NOISE, Q_MAX_V);
				program_reg(REG_INV_ALPHA_SOURCE, Q_MAX_V);
				program_reg(REG_HALF_INV_RATIO, Q_MAX_V);
				program_reg(REG_NONE, 32'h5A5A_5A5A);
				// only bit 0 counts
				program_reg(REG_SECOND_ORDER, 32'hFFFF_FFFE);
			end
		endcase
		cfg_wr_en <= 1'b0;
	endtask

	task automatic randomize_settings();
		program_reg(REG_COEF_SAMPLE, rand_q(COEF_SPAN));
		program_reg(REG_COEF_CLEAN, rand_q(COEF_SPAN));
		program_reg(REG_COEF_NOISE, rand_q(COEF_SPAN));
		program_reg(REG_SIGMA_SOURCE, rand_q(COEF_SPAN));
		program_reg(REG_INV_ALPHA_SOURCE, rand_q(COEF_SPAN));
		program_reg(REG_HALF_INV_RATIO, rand_q(COEF_SPAN));
		program_reg(REG_SECOND_ORDER, $urandom);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic send_item(input item_t it, input bit typed, input result_t typed_res);
		result_t predicted;
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			items_if.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
		end
		items_if.valid <= 1'b1;
		items_if.elem_index <= it.idx;
		items_if.sample_value <= it.sample;
		items_if.eps_value <= it.eps;
		items_if.noise_value <= it.noise;
		do @(posedge clk); while (!items_if.ready);
		predicted = predict_update(it);
		pending_results.push_back(typed ? typed_res : predicted);
	endtask

	task automatic drain();
		items_if.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	initial begin : result_check
		result_t want;
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		results_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (results_if.valid && results_if.ready) begin
				if (pending_results.size() == 0) begin
					if (error_count < MAX_REPORTS) begin
						$display("%0t: result with no item pending, actual %h/%b", $time,
							results_if.new_sample, results_if.saturated);
					end
					error_count++;
				end else begin
					want = pending_results.pop_front();
					if (results_if.new_sample !== want.new_sample) begin
						if (error_count < MAX_REPORTS) begin
							$display("%0t: new_sample mismatch, expected %h, actual %h", $time,
								want.new_sample, results_if.new_sample);
						end
						error_count++;
					end
					if (results_if.saturated !== want.saturated) begin
						if (error_count < MAX_REPORTS) begin
							$display("%0t: saturated mismatch, expected %b, actual %b", $time,
								want.saturated, results_if.saturated);
						end
						error_count++;
					end
				end
			end
			if (hold_requests != hold_seen) begin
				hold_seen = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				results_if.ready <= 1'b0;
				hold_left--;
			end else begin
				results_if.ready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	initial begin : stimulus
		item_t it;
		directed_row_t row;
		int cur_phase;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		items_if.valid = 1'b0;
		items_if.elem_index = '0;
		items_if.sample_value = '0;
		items_if.eps_value = '0;
		items_if.noise_value = '0;
		shadow.coef_sample = ONE_Q;
		shadow.coef_clean = '0;
		shadow.coef_noise = '0;
		shadow.sigma_source = '0;
		shadow.inv_alpha_source = ONE_Q;
		shadow.half_inv_ratio = '0;
		shadow.second_order = 1'b0;
		cur_phase = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			row = directed_rows[i];
			if (int'(row.phase) != cur_phase) begin
				drain();
				cur_phase = row.phase;
				load_directed_settings(cur_phase);
			end
			it.idx = row.idx;
			it.sample = row.sample;
			it.eps = row.eps;
			it.noise = row.noise;
			send_item(it, row.typed, '{row.want_sample, row.want_sat});
		end

		// modes: free-running, sender idle, receiver stall, both
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			drain();
			randomize_settings();
			case (ph % 4)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 80; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 80; end
				default: begin idle_pct = 34; stall_pct = 34; end
			endcase
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (ph == 0 && k == 100) begin
					hold_requests++;
				end
				it.idx = rand_index();
				it.sample = rand_q(VALUE_SPAN);
				it.eps = rand_q(VALUE_SPAN);
				it.noise = rand_q(VALUE_SPAN);
				send_item(it, 1'b0, '0);
			end
		end

		drain();
		repeat (12) @(posedge clk);
		if (error_count == 0) begin
			$display("dpm_solver_sde_element_update_test passed");
		end else begin
			$display("dpm_solver_sde_element_update_test failed");
		end
		$finish;
	end

endmodule
